FILE: src/mtf_pkg.sv
package mtf_pkg;

  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [SYM_W-1:0] UNKNOWN_CODE = 8'hFF;

  // direction register values
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_in;
    logic             block_end;
  } mtf_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic             block_end_out;
  } mtf_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELECT,
    ST_UPDATE
  } mtf_state_e;

  // top level to list
  typedef struct packed {
    logic             compare;
    logic             decode;
    logic [SYM_W-1:0] sym;
    logic             commit;
    logic             last;
  } mtf_cmd_t;

  // list to top level
  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic [SYM_W-1:0] value;
    logic             found;
  } mtf_sel_t;

  // broadcast to every cell
  typedef struct packed {
    logic             compare;
    logic             decode;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] dec_pos;
    logic             shift;
    logic [IDX_W-1:0] upd_pos;
    logic             restart;
  } mtf_cell_ctrl_t;

endpackage

FILE: src/mtf_cell.sv
module mtf_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mtf_pkg::IDX_W-1:0]     idx_i,
  input  mtf_pkg::mtf_cell_ctrl_t       ctrl_i,
  input  logic [mtf_pkg::SYM_W-1:0]     prev_i,
  output logic [mtf_pkg::SYM_W-1:0]     value_o,
  output logic                          match_o
);

  logic [mtf_pkg::SYM_W-1:0] value_q, value_d;
  logic                      fresh_q, fresh_d;
  logic                      match_q, match_d;
  logic                      hit;

  // a fresh cell holds its own index (identity list)
  assign value_o = fresh_q ? mtf_pkg::SYM_W'(idx_i) : value_q;
  assign match_o = match_q;

  always_comb begin
    hit = ctrl_i.decode ? (idx_i == ctrl_i.dec_pos) : (value_o == ctrl_i.sym);
    match_d = ctrl_i.compare ? hit : match_q;
    value_d = value_q;
    fresh_d = fresh_q;
    if (ctrl_i.shift && (idx_i <= ctrl_i.upd_pos)) begin
      value_d = prev_i;
      fresh_d = 1'b0;
    end
    if (ctrl_i.restart) begin
      fresh_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      match_q <= 1'b0;
    end else begin
      fresh_q <= fresh_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: src/mtf_list.sv
module mtf_list (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtf_pkg::mtf_cmd_t cmd_i,
  output mtf_pkg::mtf_sel_t sel_o
);

  localparam int unsigned N = mtf_pkg::ALPHABET_SIZE;

  logic [mtf_pkg::SYM_W-1:0] cell_val [N];
  logic [mtf_pkg::SYM_W-1:0] cell_prev [N];
  logic [N-1:0]              match;
  mtf_pkg::mtf_cell_ctrl_t   ctrl;
  mtf_pkg::mtf_sel_t         sel_q, sel_d;

  always_comb begin
    ctrl.compare = cmd_i.compare;
    ctrl.decode  = cmd_i.decode;
    ctrl.sym     = cmd_i.sym;
    // out of range positions saturate to the last entry
    if ({1'b0, cmd_i.sym} >= (mtf_pkg::SYM_W + 1)'(N)) begin
      ctrl.dec_pos = mtf_pkg::IDX_W'(N - 1);
    end else begin
      ctrl.dec_pos = mtf_pkg::IDX_W'(cmd_i.sym);
    end
    ctrl.shift   = cmd_i.commit && sel_q.found;
    ctrl.upd_pos = sel_q.pos;
    ctrl.restart = cmd_i.commit && cmd_i.last;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_prev[k] = sel_q.value;
    end else begin : g_body
      assign cell_prev[k] = cell_val[k-1];
    end
    mtf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (mtf_pkg::IDX_W'(k)),
      .ctrl_i  (ctrl),
      .prev_i  (cell_prev[k]),
      .value_o (cell_val[k]),
      .match_o (match[k])
    );
  end

  // at most one cell matches: or-reduce its index and value
  always_comb begin
    sel_d.pos   = '0;
    sel_d.value = '0;
    for (int k = 0; k < N; k++) begin
      if (match[k]) begin
        sel_d.pos   = sel_d.pos | mtf_pkg::IDX_W'(k);
        sel_d.value = sel_d.value | cell_val[k];
      end
    end
    sel_d.found = |match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else begin
      sel_q <= sel_d;
    end
  end

  assign sel_o = sel_q;

endmodule

FILE: src/move_to_front_codec_unit.sv
// byte move-to-front codec
// input channel in_valid_i/in_ready_o carries in_data_i (symbol_in, block_end);
// output channel out_valid_o/out_ready_i carries out_data_o (symbol_out,
// block_end_out). one result transaction per input transaction, in order.
// cfg_we_i/cfg_wdata_i writes the direction bit: 0 encodes a byte into its
// list position, 1 decodes a position into the byte stored there.
// the list lives in a row of 256 cells; each cell compares its entry in
// parallel, then takes its neighbor's entry to move the hit to the front.
// each item is compared on acceptance, selected, then shifted in the cells while
// its result is registered; no new item is taken until the shift step is done.
// a stalled output keeps the block in its shift step, so at most one result
// waits in the output register while the next item is accepted behind it.
// reset: the list returns to the identity, direction is encode, both
// channels are empty. block_end restores the identity after that item.
module move_to_front_codec_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mtf_pkg::mtf_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mtf_pkg::mtf_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i
);

  mtf_pkg::mtf_state_e state_q, state_d;
  logic                direction_q;
  logic                item_dec_q;
  logic                item_last_q;
  logic                out_valid_q, out_valid_d;
  mtf_pkg::mtf_out_t   out_data_q, out_data_d;
  logic                in_fire;
  logic                out_free;
  logic                commit;
  mtf_pkg::mtf_cmd_t   cmd;
  mtf_pkg::mtf_sel_t   sel;

  assign in_ready_o = (state_q == mtf_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    commit      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      mtf_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = mtf_pkg::ST_SELECT;
        end
      end
      mtf_pkg::ST_SELECT: begin
        state_d = mtf_pkg::ST_UPDATE;
      end
      mtf_pkg::ST_UPDATE: begin
        if (out_free) begin
          commit      = 1'b1;
          state_d     = mtf_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          out_data_d.block_end_out = item_last_q;
          if (item_dec_q) begin
            out_data_d.symbol_out = sel.value;
          end else if (sel.found) begin
            out_data_d.symbol_out = mtf_pkg::SYM_W'(sel.pos);
          end else begin
            out_data_d.symbol_out = mtf_pkg::UNKNOWN_CODE;
          end
        end
      end
      default: begin
        state_d = mtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.compare = in_fire;
    cmd.decode  = (direction_q == mtf_pkg::DIR_DECODE);
    cmd.sym     = in_data_i.symbol_in;
    cmd.commit  = commit;
    cmd.last    = item_last_q;
  end

  mtf_list u_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sel_o  (sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtf_pkg::ST_IDLE;
      direction_q <= mtf_pkg::DIR_ENCODE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        direction_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_fire) begin
      item_dec_q  <= (direction_q == mtf_pkg::DIR_DECODE);
      item_last_q <= in_data_i.block_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_selects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == mtf_pkg::ST_SELECT)
    else $error("accepted transaction did not move to select");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtf_pkg::ST_UPDATE && !out_free) |=> state_q == mtf_pkg::ST_UPDATE)
    else $error("list updated while output stalled");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == mtf_pkg::ST_UPDATE)
    else $error("result appeared outside the update step");

  a_decode_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtf_pkg::ST_UPDATE && item_dec_q) |-> sel.found)
    else $error("decode position selected no cell");

endmodule

FILE: tb/sv/move_to_front_codec_unit_test.sv
module move_to_front_codec_unit_test;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  mtf_pkg::mtf_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  mtf_pkg::mtf_out_t out_data_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;

  // predictor state
  logic [mtf_pkg::SYM_W-1:0] order_list [mtf_pkg::ALPHABET_SIZE];
  logic                      dir_model;

  mtf_pkg::mtf_in_t  pending_items[$];
  mtf_pkg::mtf_out_t expected_results[$];
  mtf_pkg::mtf_out_t oldest_result;
  int unsigned       error_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  logic              rx_hold = 1'b0;
  bit                hold_request = 1'b0;

  move_to_front_codec_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void restore_identity();
    for (int k = 0; k < int'(mtf_pkg::ALPHABET_SIZE); k++) begin
      order_list[k] = k[mtf_pkg::SYM_W-1:0];
    end
  endfunction

  // one accepted transaction: form the result, move the hit to the front, restore the identity at block end
  function automatic void mtf_step(input mtf_pkg::mtf_in_t item);
    int                        pos;
    bit                        hit;
    logic [mtf_pkg::SYM_W-1:0] moved;
    mtf_pkg::mtf_out_t         res;
    pos = 0;
    hit = 1'b0;
    if (dir_model == mtf_pkg::DIR_ENCODE) begin
      for (int k = 0; k < int'(mtf_pkg::ALPHABET_SIZE); k++) begin
        if (!hit && order_list[k] == item.symbol_in) begin
          hit = 1'b1;
          pos = k;
        end
      end
      res.symbol_out = hit ? pos[mtf_pkg::SYM_W-1:0] : mtf_pkg::UNKNOWN_CODE;
    end else begin
      if (int'(item.symbol_in) >= int'(mtf_pkg::ALPHABET_SIZE)) begin
        pos = int'(mtf_pkg::ALPHABET_SIZE) - 1;
      end else begin
        pos = int'(item.symbol_in);
      end
      hit = 1'b1;
      res.symbol_out = order_list[pos];
    end
    if (hit) begin
      moved = order_list[pos];
      for (int k = pos; k > 0; k--) begin
        order_list[k] = order_list[k-1];
      end
      order_list[0] = moved;
    end
    if (item.block_end) begin
      restore_identity();
    end
    res.block_end_out = item.block_end;
    expected_results = {expected_results, res};
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        mtf_step(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, %s %0d %0b",
                   $time, "actual symbol_out/block_end_out",
                   out_data_o.symbol_out, out_data_o.block_end_out);
          error_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data_o.symbol_out !== oldest_result.symbol_out) begin
            $display("%0t: symbol_out mismatch, expected %0d actual %0d",
                     $time, oldest_result.symbol_out, out_data_o.symbol_out);
            error_count++;
          end
          if (out_data_o.block_end_out !== oldest_result.block_end_out) begin
            $display("%0t: block_end_out mismatch, expected %0b actual %0b",
                     $time, oldest_result.block_end_out, out_data_o.block_end_out);
            error_count++;
          end
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (hold_request);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic queue_item(input logic [mtf_pkg::SYM_W-1:0] sym, input logic last);
    mtf_pkg::mtf_in_t item;
    item.symbol_in = sym;
    item.block_end = last;
    pending_items = {pending_items, item};
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    // idle clocks after the last result; its shift step ended when it was committed
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_direction(input logic dir);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dir;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dir_model = dir;
  endtask

  task automatic queue_random_block(input int unsigned len);
    logic [mtf_pkg::SYM_W-1:0] sym;
    logic                      last;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: sym = mtf_pkg::SYM_W'($urandom_range(255));
        1: sym = mtf_pkg::SYM_W'($urandom_range(255, 240));
        default: sym = mtf_pkg::SYM_W'($urandom_range(7));
      endcase
      if (i == len - 1) begin
        last = ($urandom_range(3) != 0);
      end else begin
        last = ($urandom_range(31) == 0);
      end
      queue_item(sym, last);
    end
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(40, 1);
      if (len > n_items - sent) begin
        len = n_items - sent;
      end
      queue_random_block(len);
      sent += len;
      if ($urandom_range(2) == 0) begin
        set_direction(1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    restore_identity();
    dir_model = mtf_pkg::DIR_ENCODE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_direction(mtf_pkg::DIR_ENCODE);
    queue_item(8'd0, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd0, 1'b0);
    queue_item(8'd128, 1'b0);
    queue_item(8'd128, 1'b1);
    queue_item(8'd128, 1'b0);
    queue_item(8'd1, 1'b1);

    set_direction(mtf_pkg::DIR_DECODE);
    queue_item(8'd0, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd1, 1'b0);
    queue_item(8'd128, 1'b0);
    queue_item(8'd0, 1'b1);
    queue_item(8'd255, 1'b1);

    // direction flips in the middle of a block, list carries over
    queue_item(8'd5, 1'b0);
    queue_item(8'd9, 1'b0);
    set_direction(mtf_pkg::DIR_ENCODE);
    queue_item(8'd5, 1'b0);
    queue_item(8'd9, 1'b0);
    queue_item(8'd200, 1'b1);
    wait_drained();

    send_idle_pct = 14;
    recv_idle_pct = 87;
    run_random_phase(170);
    wait_drained();

    send_idle_pct = 87;
    recv_idle_pct = 14;
    run_random_phase(170);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    queue_random_block(40);
    wait_drained();
    run_random_phase(170);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
